>>> src/rle_pkg.sv
// rle_pkg: shared types and constants of the byte run-length encoder
// no dependencies; used by every module of the block
package rle_pkg;

  localparam int DATA_W      = 8;
  localparam int MAX_RUN_DEF = 255;
  localparam int RES_MAX     = 3;
  localparam int RES_NUM_W   = $clog2(RES_MAX + 1);
  localparam int FIFO_DEPTH  = 4;

  typedef struct packed {
    logic [DATA_W-1:0] in_byte;
    logic              in_last;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              out_is_count;
    logic              out_last;
  } out_t;

  typedef struct packed {
    logic [RES_NUM_W-1:0]  num;
    out_t [RES_MAX-1:0]    res;
  } push_t;

endpackage

>>> src/rle_byte_encoder.sv
// rle_byte_encoder: top level of the byte run-length encoder
// depends on rle_pkg, rle_core, rle_out_fifo
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_ready   in_item  (rle_pkg::in_t)
//   output    out        out_valid / out_ready out_item (rle_pkg::out_t)
//
// one input transaction per cycle while the result queue holds at most one entry
// each transaction yields 0 to 3 results, drained one per cycle while out_ready is high from a 4-entry queue
// results leave in the cycle after the transaction that caused them at the earliest
// reset empties the queue and closes any open run
// a stalled output fills the queue and drops in_ready until space returns
module rle_byte_encoder #(
  parameter int MAX_RUN = rle_pkg::MAX_RUN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rle_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output rle_pkg::out_t out_item
);
  import rle_pkg::*;

  push_t push;
  logic  room;
  logic  accept;

  assign in_ready = room;
  assign accept   = in_valid && room;

  rle_core #(.MAX_RUN(MAX_RUN)) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .push   (push)
  );

  rle_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> src/rle_core.sv
// rle_core: run state registers and the per-transaction result generator
// depends on rle_pkg
module rle_core #(
  parameter int MAX_RUN = rle_pkg::MAX_RUN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  rle_pkg::in_t  item,
  output rle_pkg::push_t push
);
  import rle_pkg::*;

  logic [DATA_W-1:0] run_byte, run_byte_next;
  logic [DATA_W-1:0] run_length, run_length_next;
  logic              run_open, run_open_next;

  always_comb begin
    logic extend;
    logic [RES_NUM_W-1:0] n;
    extend = run_open && (item.in_byte == run_byte) && (run_length < DATA_W'(MAX_RUN));
    n = '0;
    push.res = '0;
    run_byte_next   = run_byte;
    run_length_next = run_length;
    run_open_next   = 1'b1;
    if (!extend && run_open) begin
      push.res[n] = '{out_byte: run_byte, out_is_count: 1'b0, out_last: 1'b0};
      n = n + 1'b1;
      if (run_length >= DATA_W'(2)) begin
        push.res[n] = '{out_byte: run_length, out_is_count: 1'b1, out_last: 1'b0};
        n = n + 1'b1;
      end
    end
    if (extend) begin
      run_length_next = run_length + 1'b1;
    end else begin
      run_byte_next   = item.in_byte;
      run_length_next = DATA_W'(1);
    end
    if (item.in_last) begin
      push.res[n] = '{out_byte: run_byte_next, out_is_count: 1'b0, out_last: 1'b0};
      n = n + 1'b1;
      if (run_length_next >= DATA_W'(2)) begin
        push.res[n] = '{out_byte: run_length_next, out_is_count: 1'b1, out_last: 1'b0};
        n = n + 1'b1;
      end
      push.res[n - 1'b1].out_last = 1'b1;
      run_open_next   = 1'b0;
      run_length_next = '0;
    end
    push.num = accept ? n : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_byte   <= '0;
      run_length <= '0;
      run_open   <= 1'b0;
    end else if (accept) begin
      run_byte   <= run_byte_next;
      run_length <= run_length_next;
      run_open   <= run_open_next;
    end
  end

endmodule

>>> src/rle_out_fifo.sv
// rle_out_fifo: result queue, takes up to three results a cycle, hands out one
// depends on rle_pkg
module rle_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  rle_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output rle_pkg::out_t  out_item
);
  import rle_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  out_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_item  = mem[rptr];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= CNT_W'(FIFO_DEPTH - RES_MAX));

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (RES_NUM_W'(i) < push.num) begin
        mem[wptr + PTR_W'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.num);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CNT_W'(push.num) - CNT_W'(pop);
    end
  end

endmodule

>>> src/rle_checker.sv
// rle_checker: port-level assertions for rle_byte_encoder, bound to the top level
// depends on rle_pkg
module rle_checker #(
  parameter int MAX_RUN = rle_pkg::MAX_RUN_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input rle_pkg::in_t  in_item,
  input logic          out_valid,
  input logic          out_ready,
  input rle_pkg::out_t out_item
);
  import rle_pkg::*;

  logic allow_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_count <= 1'b0;
    end else if (out_valid && out_ready) begin
      allow_count <= !out_item.out_is_count;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input transaction changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output transaction changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_is_count |->
      out_item.out_byte >= DATA_W'(2) && out_item.out_byte <= DATA_W'(MAX_RUN))
    else $error("run count out of range");

  a_count_after_literal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_is_count |-> allow_count)
    else $error("run count not preceded by a literal");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind rle_byte_encoder rle_checker #(.MAX_RUN(MAX_RUN)) u_rle_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

>>> tb/rle_byte_encoder_tb.sv
`timescale 1ns / 100ps
// rle_byte_encoder_tb: self-checking testbench for the byte run-length encoder
// depends on rle_pkg and rle_byte_encoder; directed rows, then random streams
// each result is checked against its given values or a run-length predictor under varied idling
module rle_byte_encoder_tb;
  import rle_pkg::*;

  localparam int RUN_LIMIT    = MAX_RUN_DEF;
  localparam int PREDICTED    = -1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 120;

  typedef struct {
    in_t  item;
    int   reps;
    int   n;
    out_t r0;
    out_t r1;
    out_t r2;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  logic [DATA_W-1:0] cur_byte = '0;
  logic [DATA_W-1:0] cur_len = '0;
  logic              cur_open = 1'b0;

  out_t      fresh_results[$];
  out_t      pending_results[$];
  stim_row_t stim_rows[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  rle_byte_encoder #(.MAX_RUN(RUN_LIMIT)) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic out_t res(input logic [7:0] b, input logic c, input logic l);
    return '{out_byte: b, out_is_count: c, out_last: l};
  endfunction

  // close the open run: literal, then count when two or longer
  function automatic void flush_run();
    fresh_results.push_back(res(cur_byte, 1'b0, 1'b0));
    if (cur_len >= 2) fresh_results.push_back(res(cur_len, 1'b1, 1'b0));
    cur_open = 1'b0;
    cur_len = '0;
  endfunction

  function automatic void encode_byte(input in_t it);
    out_t tail;
    fresh_results.delete();
    if (cur_open && it.in_byte == cur_byte && cur_len < RUN_LIMIT) begin
      cur_len = cur_len + 1'b1;
    end else begin
      if (cur_open) flush_run();
      cur_byte = it.in_byte;
      cur_len = 8'd1;
      cur_open = 1'b1;
    end
    if (it.in_last) begin
      flush_run();
      tail = fresh_results.pop_back();
      tail.out_last = 1'b1;
      fresh_results.push_back(tail);
    end
  endfunction

  task automatic push_byte(input in_t it, input int n_given = PREDICTED,
                           input out_t g0 = '0, input out_t g1 = '0, input out_t g2 = '0);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_byte(it);
    if (n_given == PREDICTED) begin
      foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
    end else begin
      if (n_given > 0) pending_results.push_back(g0);
      if (n_given > 1) pending_results.push_back(g1);
      if (n_given > 2) pending_results.push_back(g2);
    end
  endtask

  function automatic void add_row(input logic [7:0] b, input logic l, input int reps,
                                  input int n = PREDICTED, input out_t r0 = '0,
                                  input out_t r1 = '0, input out_t r2 = '0);
    stim_row_t row;
    row.item.in_byte = b;
    row.item.in_last = l;
    row.reps = reps;
    row.n = n;
    row.r0 = r0;
    row.r1 = r1;
    row.r2 = r2;
    stim_rows.push_back(row);
  endfunction

  task automatic random_streams(input int n_items);
    int   sent;
    int   runs;
    int   len;
    int   roll;
    logic [7:0] b;
    logic [7:0] prev;
    in_t  it;
    sent = 0;
    prev = 8'($urandom);
    while (sent < n_items) begin
      runs = $urandom_range(1, 6);
      for (int k = 0; k < runs; k++) begin
        roll = $urandom_range(99);
        if (roll < 20) b = prev;
        else if (roll < 30) b = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        else b = 8'($urandom);
        roll = $urandom_range(99);
        if (roll < 50) len = 1;
        else if (roll < 85) len = $urandom_range(2, 6);
        else len = $urandom_range(7, 20);
        for (int j = 0; j < len; j++) begin
          it.in_byte = b;
          it.in_last = (k == runs - 1 && j == len - 1) || ($urandom_range(99) < 3);
          push_byte(it);
          sent++;
        end
        prev = b;
      end
    end
  endtask

  // result side: check, then pick the next ready value
  initial begin
    out_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction byte %02h count %0b last %0b",
                                    out_item.out_byte, out_item.out_is_count,
                                    out_item.out_last));
        end else begin
          want = pending_results.pop_front();
          if (out_item.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                      out_item.out_byte, want.out_byte));
          if (out_item.out_is_count !== want.out_is_count)
            report_mismatch($sformatf("out_is_count %0b, wanted %0b",
                                      out_item.out_is_count, want.out_is_count));
          if (out_item.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %0b, wanted %0b",
                                      out_item.out_last, want.out_last));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    add_row(8'h00, 1'b1, 1, 1, res(8'h00, 1'b0, 1'b1));
    add_row(8'hFF, 1'b1, 1, 1, res(8'hFF, 1'b0, 1'b1));
    add_row(8'hA5, 1'b0, 1, 0);
    add_row(8'hA5, 1'b0, 1, 0);
    add_row(8'hA5, 1'b1, 1, 2, res(8'hA5, 1'b0, 1'b0), res(8'h03, 1'b1, 1'b1));
    add_row(8'h12, 1'b0, 1, 0);
    add_row(8'h34, 1'b0, 1, 1, res(8'h12, 1'b0, 1'b0));
    add_row(8'h34, 1'b1, 1, 2, res(8'h34, 1'b0, 1'b0), res(8'h02, 1'b1, 1'b1));
    add_row(8'h55, 1'b0, 1, 0);
    add_row(8'h66, 1'b1, 1, 2, res(8'h55, 1'b0, 1'b0), res(8'h66, 1'b0, 1'b1));
    // full run, then an equal last byte
    add_row(8'hC3, 1'b0, RUN_LIMIT);
    add_row(8'hC3, 1'b1, 1, 3, res(8'hC3, 1'b0, 1'b0), res(8'(RUN_LIMIT), 1'b1, 1'b0),
            res(8'hC3, 1'b0, 1'b1));
    add_row(8'h5A, 1'b0, 3);
    add_row(8'h81, 1'b0, 2);
    add_row(8'h5A, 1'b1, 1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      for (int j = 0; j < stim_rows[i].reps - 1; j++) push_byte(stim_rows[i].item);
      push_byte(stim_rows[i].item, stim_rows[i].n, stim_rows[i].r0, stim_rows[i].r1,
                stim_rows[i].r2);
    end

    // no idling, with one long receiver hold-off up front
    hold_cycles = 150;
    random_streams(RANDOM_ITEMS / 4);

    send_idle_pct = 57;
    recv_stall_pct = 0;
    random_streams(RANDOM_ITEMS / 4);

    send_idle_pct = 0;
    recv_stall_pct = 57;
    random_streams(RANDOM_ITEMS / 4);

    send_idle_pct = 38;
    recv_stall_pct = 38;
    random_streams(RANDOM_ITEMS / 4);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rle_pkg.sv
src/rle_core.sv
src/rle_out_fifo.sv
src/rle_byte_encoder.sv
src/rle_checker.sv
tb/rle_byte_encoder_tb.sv
